// ===== hdl/sine_cosine_table_interpolator_core_defines.svh =====
`ifndef SINE_COSINE_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define SINE_COSINE_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// Concurrent assertion on the rising clock edge, off while reset is low.
`define SCTI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check with the block clock and reset names.
`define SCTI_ASSERT_BLK(label, prop, msg) \
  `SCTI_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/scti_pkg.sv =====
package scti_pkg;

  localparam int unsigned TABLE_POINTS_DEF = 512;
  localparam int unsigned ROM_W = 17;
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned FRAC_W = 16;
  localparam logic [31:0] TURN_SCALE_Q32 = 32'd683565276;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sd32767;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -16'sd32767;

  typedef struct packed {
    logic rom;
    logic mul;
    logic out;
  } scti_lane_en_t;

  function automatic logic signed [ROM_W-1:0] rom_entry(input logic [31:0] t);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] vm;
    quad = t[31:30];
    r = {34'd0, t[29:0]};
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    y = (r * HALF_PI_Q30 + (ONE_Q30 >> 1)) >> 30;
    y2 = (y * y + (ONE_Q30 >> 1)) >> 30;
    term = y;
    pos = y;
    neg = 64'd0;
    term = ((term * y2) >> 30) / 64'd6;
    neg = neg + term;
    term = ((term * y2) >> 30) / 64'd20;
    pos = pos + term;
    term = ((term * y2) >> 30) / 64'd42;
    neg = neg + term;
    term = ((term * y2) >> 30) / 64'd72;
    pos = pos + term;
    term = ((term * y2) >> 30) / 64'd110;
    neg = neg + term;
    term = ((term * y2) >> 30) / 64'd156;
    pos = pos + term;
    term = ((term * y2) >> 30) / 64'd210;
    neg = neg + term;
    s = (pos > neg) ? (pos - neg) : 64'd0;
    vm = (s + 64'd16384) >> 15;
    if (quad[1]) begin
      return -$signed(vm[ROM_W-1:0]);
    end
    return $signed(vm[ROM_W-1:0]);
  endfunction

endpackage

// ===== hdl/scti_lane.sv =====
module scti_lane #(
  parameter int unsigned TABLE_POINTS = scti_pkg::TABLE_POINTS_DEF,
  localparam int unsigned IW = $clog2(TABLE_POINTS)
) (
  input  logic                                 clk_i,
  input  scti_pkg::scti_lane_en_t              en_i,
  input  logic [IW-1:0]                        addr_i,
  input  logic [scti_pkg::FRAC_W-1:0]          frac_i,
  output logic signed [scti_pkg::VALUE_W-1:0]  value_o
);
  import scti_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_POINTS + 1);
  localparam int unsigned PRW = 36;
  localparam int unsigned SUMW = 21;

  logic signed [ROM_W-1:0] rom_w [TABLE_POINTS+1];

  for (genvar g = 0; g <= TABLE_POINTS; g++) begin : g_rom
    localparam logic [31:0] T = 32'((64'(g) << 32) / TABLE_POINTS);
    assign rom_w[g] = rom_entry(T);
  end

  logic [AW-1:0]            addr0_w;
  logic [AW-1:0]            addr1_w;
  logic signed [ROM_W-1:0]  e0_q;
  logic signed [ROM_W-1:0]  e1_q;
  logic [FRAC_W-1:0]        frac_q;
  logic signed [ROM_W:0]    diff_w;
  logic signed [PRW-1:0]    prod_d;
  logic signed [PRW-1:0]    prod_q;
  logic signed [ROM_W-1:0]  base_q;
  logic signed [SUMW-1:0]   sum_w;
  logic signed [VALUE_W-1:0] value_d;
  logic signed [VALUE_W-1:0] value_q;

  assign addr0_w = AW'(addr_i);
  assign addr1_w = AW'(addr_i) + AW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i.rom) begin
      e0_q   <= rom_w[addr0_w];
      e1_q   <= rom_w[addr1_w];
      frac_q <= frac_i;
    end
  end

  assign diff_w = (ROM_W+1)'(e1_q) - (ROM_W+1)'(e0_q);
  assign prod_d = PRW'(diff_w) * PRW'($signed({1'b0, frac_q})) + PRW'(32768);

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= prod_d;
      base_q <= e0_q;
    end
  end

  assign sum_w = SUMW'(base_q) + SUMW'($signed(prod_q[PRW-1:16]));

  always_comb begin
    if (sum_w > SUMW'(VALUE_MAX)) begin
      value_d = VALUE_MAX;
    end else if (sum_w < SUMW'(VALUE_MIN)) begin
      value_d = VALUE_MIN;
    end else begin
      value_d = sum_w[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ===== hdl/sine_cosine_table_interpolator_core.sv =====
// Sine and cosine of an angle by table lookup with linear interpolation.
// Slave stream: s_axis_tdata carries one angle in radians, signed Q16.16.
// Master stream: m_axis_tdata carries the sine (bits 15:0) and the cosine
// (bits 31:16) of that angle, both signed Q1.15, clamped to +/-32767.
// Every angle gives exactly one result, in order.
// The path from the accepting edge to m_axis_tvalid runs through six
// register stages: turn multiply, index multiply, quarter-turn offset,
// registered table read, slope multiply, rounding and clamp to the output.
// Throughput: one transaction per clock cycle while the output is not
// stalled, set by the six-stage pipeline; each stage holds one angle.
// Stall: while m_axis_tready is low the output holds; earlier stages keep
// filling their empty slots, and s_axis_tready falls once all six are full.
// Reset: rst_ni low clears all valid bits at once; the block accepts input
// on the first edge after reset is released.
module sine_cosine_table_interpolator_core #(
  parameter int unsigned TABLE_POINTS = scti_pkg::TABLE_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [scti_pkg::ANGLE_W-1:0]  s_axis_tdata,   // [31:0] angle
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*scti_pkg::VALUE_W-1:0] m_axis_tdata   // [15:0] sine_value, [31:16] cosine_value
);
  import scti_pkg::*;

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned IW = $clog2(TABLE_POINTS);
  localparam int unsigned AW = $clog2(TABLE_POINTS + 1);
  localparam int unsigned TPW = 63;
  localparam int unsigned PW = 32 + AW;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] adv_w;

  always_comb begin
    adv_w[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv_w[k] = !valid_q[k] || adv_w[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv_w[0]) begin
        valid_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv_w[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv_w[0];
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];

  logic [TPW-1:0] turn_w;
  logic [31:0]    phase_q;

  assign turn_w = TPW'($signed(s_axis_tdata)) * TPW'(TURN_SCALE_Q32);

  always_ff @(posedge clk_i) begin
    if (adv_w[0]) begin
      phase_q <= turn_w[47:16];
    end
  end

  logic [PW-1:0]     scaled_w;
  logic [IW-1:0]     idx1_q;
  logic [FRAC_W-1:0] frac1_q;

  assign scaled_w = PW'(phase_q) * PW'(TABLE_POINTS);

  always_ff @(posedge clk_i) begin
    if (adv_w[1]) begin
      idx1_q  <= scaled_w[32 +: IW];
      frac1_q <= scaled_w[31:16];
    end
  end

  logic [IW:0]       shift_w;
  logic [IW-1:0]     idx_c_d;
  logic [IW-1:0]     idx_s2_q;
  logic [IW-1:0]     idx_c2_q;
  logic [FRAC_W-1:0] frac2_q;

  assign shift_w = (IW+1)'(idx1_q) + (IW+1)'(TABLE_POINTS / 4);

  always_comb begin
    if (shift_w >= (IW+1)'(TABLE_POINTS)) begin
      idx_c_d = IW'(shift_w - (IW+1)'(TABLE_POINTS));
    end else begin
      idx_c_d = shift_w[IW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w[2]) begin
      idx_s2_q <= idx1_q;
      idx_c2_q <= idx_c_d;
      frac2_q  <= frac1_q;
    end
  end

  scti_lane_en_t            lane_en;
  logic signed [VALUE_W-1:0] sine_w;
  logic signed [VALUE_W-1:0] cosine_w;

  assign lane_en.rom = adv_w[3];
  assign lane_en.mul = adv_w[4];
  assign lane_en.out = adv_w[5];

  scti_lane #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_sine_lane (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .addr_i  (idx_s2_q),
    .frac_i  (frac2_q),
    .value_o (sine_w)
  );

  scti_lane #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_cosine_lane (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .addr_i  (idx_c2_q),
    .frac_i  (frac2_q),
    .value_o (cosine_w)
  );

  assign m_axis_tdata = {cosine_w, sine_w};

endmodule

// ===== hdl/scti_checker.sv =====
`include "sine_cosine_table_interpolator_core_defines.svh"

module scti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic signed [15:0] sine_w;
  logic signed [15:0] cosine_w;
  logic [16:0]        sine_abs_w;
  logic [16:0]        cosine_abs_w;
  logic [17:0]        mag_w;

  assign sine_w       = m_axis_tdata[15:0];
  assign cosine_w     = m_axis_tdata[31:16];
  assign sine_abs_w   = sine_w[15] ? 17'(-17'(sine_w)) : 17'(sine_w);
  assign cosine_abs_w = cosine_w[15] ? 17'(-17'(cosine_w)) : 17'(cosine_w);
  assign mag_w        = 18'(sine_abs_w) + 18'(cosine_abs_w);

  `SCTI_ASSERT_BLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed or dropped while stalled")
  `SCTI_ASSERT_BLK(a_ready_through, m_axis_tready |-> s_axis_tready, "input stalled although the output side is ready")
  `SCTI_ASSERT_BLK(a_clamp, m_axis_tvalid |-> sine_w != -16'sd32768 && cosine_w != -16'sd32768, "result outside the clamp range")
  `SCTI_ASSERT_BLK(a_unit_circle, m_axis_tvalid |-> mag_w >= 18'd32000, "sine and cosine do not lie near the unit circle")

endmodule

bind sine_cosine_table_interpolator_core scti_checker u_scti_checker (.*);

// ===== tb/scti_trig_checker.sv =====
module scti_trig_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [scti_pkg::ANGLE_W-1:0]    s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [2*scti_pkg::VALUE_W-1:0]  m_axis_tdata,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     trig_pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POINTS = scti_pkg::TABLE_POINTS_DEF;
  localparam longint TURN_SCALE = 64'sd683565276;
  localparam bit [63:0] Q30_ONE = 64'h0000_0000_4000_0000;
  localparam bit [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam longint CLAMP_HI = 32767;
  localparam longint CLAMP_LO = -32767;

  typedef struct packed {
    logic [scti_pkg::ANGLE_W-1:0]        angle;
    logic signed [scti_pkg::VALUE_W-1:0] sine;
    logic signed [scti_pkg::VALUE_W-1:0] cosine;
  } trig_pair_t;

  longint     sine_rom [0:POINTS];
  trig_pair_t trig_expected_q [$];

  // Series sine of table point i, Q2.30 internally, rounded to Q1.15.
  function automatic longint sine_point(input int unsigned i);
    bit [31:0] t;
    bit [63:0] r;
    bit [63:0] y;
    bit [63:0] y2;
    bit [63:0] term;
    bit [63:0] pos;
    bit [63:0] neg;
    bit [63:0] s;
    longint    v;
    int unsigned k;
    t = 32'((64'(i) << 32) / 64'(POINTS));
    r = {34'd0, t[29:0]};
    if (t[30]) begin
      r = Q30_ONE - r;
    end
    y = (r * Q30_HALF_PI + (Q30_ONE >> 1)) >> 30;
    y2 = (y * y + (Q30_ONE >> 1)) >> 30;
    term = y;
    pos = y;
    neg = 64'd0;
    for (k = 1; k <= 7; k++) begin
      term = ((term * y2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > neg) ? (pos - neg) : 64'd0;
    v = longint'((s + 64'd16384) >> 15);
    if (t[31]) begin
      v = -v;
    end
    return v;
  endfunction

  function automatic logic signed [15:0] lerp_clamped(input int unsigned idx,
                                                      input int unsigned frac);
    longint e0;
    longint e1;
    longint d;
    longint v;
    e0 = sine_rom[idx];
    e1 = sine_rom[idx + 1];
    d = (e1 - e0) * longint'(frac) + 32768;
    v = e0 + (d >>> 16);
    if (v > CLAMP_HI) begin
      v = CLAMP_HI;
    end
    if (v < CLAMP_LO) begin
      v = CLAMP_LO;
    end
    return 16'(v);
  endfunction

  function automatic trig_pair_t predict_trig(input logic [31:0] angle);
    trig_pair_t  p;
    longint      a;
    bit [63:0]   turn;
    bit [31:0]   phase;
    bit [63:0]   scaled;
    int unsigned idx;
    int unsigned idx_c;
    int unsigned frac;
    a = longint'(signed'(angle));
    turn = a * TURN_SCALE;
    phase = turn[47:16];
    scaled = 64'(phase) * 64'(POINTS);
    idx = scaled[63:32];
    frac = scaled[31:16];
    idx_c = (idx + POINTS / 4) % POINTS;
    p.angle = angle;
    p.sine = lerp_clamped(idx, frac);
    p.cosine = lerp_clamped(idx_c, frac);
    return p;
  endfunction

  initial begin
    mismatch_count_o = 0;
    for (int unsigned i = 0; i <= POINTS; i++) begin
      sine_rom[i] = sine_point(i);
    end
  end

  assign trig_pending_o = trig_expected_q.size();

  always @(posedge clk_i) begin
    trig_pair_t want;
    logic signed [15:0] got_sin;
    logic signed [15:0] got_cos;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_sin = m_axis_tdata[15:0];
        got_cos = m_axis_tdata[31:16];
        if (trig_expected_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected result sin=%0d cos=%0d", $time, got_sin, got_cos);
          end
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = trig_expected_q.pop_front();
          if (got_sin !== want.sine || got_cos !== want.cosine) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: angle %h: sin exp %0d got %0d, cos exp %0d got %0d", $time,
                       want.angle, want.sine, got_sin, want.cosine, got_cos);
            end
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        trig_expected_q.push_back(predict_trig(s_axis_tdata));
      end
    end
  end

endmodule

// ===== tb/tb_sine_cosine_table_interpolator_core.sv =====
module tb_sine_cosine_table_interpolator_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS = 1550;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [31:0] HALF_PI_Q16 = 32'd102944;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  int unsigned mismatch_count;
  int unsigned trig_pending;
  int unsigned quiet_cycles;
  bit          steady;

  sine_cosine_table_interpolator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scti_trig_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .trig_pending_o   (trig_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[sine_cosine_table_interpolator_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_angle(input logic [31:0] angle);
    if (!steady && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 13) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= angle;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return $urandom;
    end else if (pick < 80) begin
      return 32'($signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000);
    end
    // near a quadrant boundary, where the output clamps or crosses zero
    return 32'($signed(HALF_PI_Q16) * ($signed($urandom_range(16)) - 8)
               + $signed($urandom_range(64)) - 32);
  endfunction

  initial begin
    logic [31:0] directed_q [$];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    quiet_cycles = 0;
    steady = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h0001_0000, 32'hFFFF_0000, 32'd102943, 32'd102944, 32'd205887,
                   32'd205888, 32'd308831, 32'd308832, 32'd411775, 32'd411776,
                   32'hFFFE_6DE0, 32'hFFFC_DBC1, 32'd804, 32'd805, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h0000_FFFF};
    foreach (directed_q[i]) begin
      send_angle(directed_q[i]);
    end

    for (int unsigned n = directed_q.size(); n < ITEMS; n++) begin
      steady = (n >= 600 && n < 900);
      send_angle(random_angle());
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (trig_pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && trig_pending == 0) begin
      $display("[sine_cosine_table_interpolator_core] OK");
    end else begin
      $display("[sine_cosine_table_interpolator_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/scti_pkg.sv
hdl/scti_lane.sv
hdl/sine_cosine_table_interpolator_core.sv
hdl/scti_checker.sv
tb/scti_trig_checker.sv
tb/tb_sine_cosine_table_interpolator_core.sv
